@@ design/ppb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared types, constants and codes of the priority packet buffer.
// ----------------------------------------------------------------------------
package ppb_pkg;

	localparam int QUEUE_SLOTS = 32;
	localparam int IDX_W       = $clog2(QUEUE_SLOTS);
	localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic [40:0] TMAX41    = {41{1'b1}};
	localparam logic [39:0] TMAX40    = {40{1'b1}};
	localparam logic [23:0] BYTES_MAX = {24{1'b1}};
	localparam logic [22:0] TX_SCALE  = 23'd8000000;
	localparam logic [7:0]  TAG_MAX   = 8'd255;

	localparam int DIV_STEPS = 41;
	localparam int DIVC_W    = 6;

	// register indexes
	localparam logic [1:0] REG_RATE   = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_DELAY  = 2'd3;

	localparam logic [39:0] RATE_RST  = 40'd1000000000;
	localparam logic [23:0] LIMIT_RST = 24'd65536;

	// event kinds
	localparam logic [2:0] EV_TX    = 3'd0;
	localparam logic [2:0] EV_EVICT = 3'd1;
	localparam logic [2:0] EV_ADMIT = 3'd2;
	localparam logic [2:0] EV_DROP  = 3'd3;
	localparam logic [2:0] EV_FLUSH = 3'd4;

	localparam logic       ACT_ARRIVE = 1'b0;
	localparam logic       ACT_FLUSH  = 1'b1;
	localparam logic [1:0] CLS_BULK   = 2'd0;
	localparam logic [1:0] CLS_CTRL   = 2'd1;
	localparam logic [1:0] CLS_PLAIN  = 2'd2;
	localparam logic [1:0] CLS_PLAIN2 = 2'd3;

	typedef struct packed {
		logic        action;
		logic [39:0] arrival_us;
		logic [15:0] packet_bytes;
		logic [1:0]  packet_class;
		logic [7:0]  priority_level;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [39:0] start_time_us;
		logic [39:0] queue_delay_us;
		logic [39:0] origin_time_us;
		logic [15:0] event_bytes;
		logic [1:0]  event_class;
		logic [7:0]  event_priority;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [39:0] arrival;
		logic [15:0] bytes;
		logic [1:0]  cls;
		logic [7:0]  tag;
		logic [31:0] seq;
	} ent_t;

	typedef struct packed {
		logic             load;
		logic             epoch;
		logic             ent_load;
		logic             send;
		logic             link_upd;
		logic             wr_en;
		logic             cnt_set;
		logic             evict;
		logic             admit;
		logic             drop;
		logic             flush_done;
		logic [IDX_W-1:0] rd_addr;
		logic [IDX_W-1:0] wr_addr;
		logic [CNT_W-1:0] cnt_val;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             flush;
		logic             sort_epoch;
		logic             key_lt;
		logic             start_ok;
		logic             full;
		logic             ctl_push;
		logic             rd_bulk;
		logic             push_ok;
		logic             div_done;
	} status_t;

endpackage

@@ design/ppb_ram.sv @@
// ----------------------------------------------------------------------------
// ppb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/ppb_div.sv @@
// ----------------------------------------------------------------------------
// ppb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [40:0] num,
	input  logic [39:0] den,
	output logic        done,
	output logic [40:0] quo
);
	import ppb_pkg::*;

	logic              run_q;
	logic [DIVC_W-1:0] cnt_q;
	logic [39:0]       rem_q;
	logic [40:0]       dvd_q;
	logic [39:0]       den_q;
	logic              done_q;
	logic [40:0]       rem_sh;
	logic              fit;

	assign rem_sh = {rem_q, dvd_q[40]};
	assign fit    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= DIVC_W'(DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIVC_W'(1);
				if (cnt_q == DIVC_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= num;
			den_q <= den;
		end else if (run_q) begin
			// quotient bits shift in where dividend bits leave
			rem_q <= fit ? 40'(rem_sh - {1'b0, den_q}) : rem_sh[39:0];
			dvd_q <= {dvd_q[39:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

@@ design/ppb_dp.sv @@
// ----------------------------------------------------------------------------
// ppb_dp
// Datapath: registers, link and sorter times, slot store, divider, results.
// ----------------------------------------------------------------------------
module ppb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppb_pkg::PADDR_W-1:0]   paddr,
	input  logic [ppb_pkg::PDATA_W-1:0]   pwdata,
	output logic [ppb_pkg::PDATA_W-1:0]   prdata,
	input  ppb_pkg::item_t                item,
	input  ppb_pkg::cmd_t                 cmd,
	output ppb_pkg::status_t              st,
	output ppb_pkg::result_t              result,
	output logic                          result_valid
);
	import ppb_pkg::*;

	function automatic logic [40:0] sat41(input logic [40:0] a, input logic [40:0] b);
		logic [41:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[41] ? TMAX41 : s[40:0];
	endfunction

	function automatic logic [39:0] sat40(input logic [40:0] a);
		return a[40] ? TMAX40 : a[39:0];
	endfunction

	function automatic logic [39:0] key(input ent_t e);
		return {8'(TAG_MAX - e.tag), e.seq};
	endfunction

	logic [39:0]      rate_q;
	logic [23:0]      limit_q, period_q, delay_q;
	item_t            in_q;
	ent_t             ent_q;
	logic [CNT_W-1:0] cnt_q;
	logic [23:0]      held_q;
	logic [31:0]      seq_q;
	logic [40:0]      link_free_q, sorter_free_q, next_epoch_q;
	logic [38:0]      mul_s1;
	logic             mul_vld_s1;
	result_t          result_q;
	logic             result_valid_q;

	ent_t        rdata, wdata, new_ent;
	logic [40:0] limit, start, delay_t, quo;
	logic [23:0] gap, held_sub;
	logic [39:0] rate_eff;
	logic        div_done, cfg_wr;
	result_t     ev;

	ppb_ram #(.WIDTH($bits(ent_t)), .DEPTH(QUEUE_SLOTS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cmd.wr_addr),
		.wdata (wdata),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	assign rate_eff = (rate_q == '0) ? 40'd1 : rate_q;

	ppb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_vld_s1),
		.num    (41'(mul_s1) + 41'(rate_eff) - 41'd1),
		.den    (rate_eff),
		.done   (div_done),
		.quo    (quo)
	);

	assign new_ent = '{arrival: in_q.arrival_us, bytes: in_q.packet_bytes,
		cls: in_q.packet_class, tag: in_q.priority_level, seq: seq_q};
	assign wdata = cmd.admit ? new_ent : rdata;

	assign limit    = (in_q.action == ACT_FLUSH) ? TMAX41 : {1'b0, in_q.arrival_us};
	assign gap      = (period_q > delay_q) ? period_q : delay_q;
	assign start    = ({1'b0, ent_q.arrival} > link_free_q) ? {1'b0, ent_q.arrival}
		: link_free_q;
	assign delay_t  = start - {1'b0, ent_q.arrival};
	assign held_sub = (held_q >= {8'd0, ent_q.bytes}) ? held_q - {8'd0, ent_q.bytes} : '0;

	always_comb begin
		st.cnt        = cnt_q;
		st.flush      = in_q.action == ACT_FLUSH;
		st.sort_epoch = (period_q == '0) || (limit >= next_epoch_q);
		st.key_lt     = key(rdata) < key(ent_q);
		st.start_ok   = start <= limit;
		st.full       = ({1'b0, held_q} + 25'(in_q.packet_bytes) > {1'b0, limit_q})
			|| (cnt_q >= CNT_W'(QUEUE_SLOTS));
		st.ctl_push   = (in_q.packet_class == CLS_CTRL)
			&& ({1'b0, in_q.arrival_us} >= sorter_free_q);
		st.rd_bulk    = rdata.cls == CLS_BULK;
		st.push_ok    = {1'b0, held_sub} + 25'(in_q.packet_bytes) <= {1'b0, BYTES_MAX};
		st.div_done   = div_done;
	end

	always_comb begin
		ev = '0;
		if (cmd.send) begin
			ev.event_kind     = EV_TX;
			ev.start_time_us  = sat40(start);
			ev.queue_delay_us = sat40(delay_t);
			ev.origin_time_us = ent_q.arrival;
			ev.event_bytes    = ent_q.bytes;
			ev.event_class    = ent_q.cls;
			ev.event_priority = ent_q.tag;
		end else if (cmd.evict) begin
			ev.event_kind     = EV_EVICT;
			ev.origin_time_us = ent_q.arrival;
			ev.event_bytes    = ent_q.bytes;
			ev.event_class    = ent_q.cls;
			ev.event_priority = ent_q.tag;
		end else if (cmd.admit || cmd.drop) begin
			ev.event_kind     = cmd.admit ? EV_ADMIT : EV_DROP;
			ev.origin_time_us = in_q.arrival_us;
			ev.event_bytes    = in_q.packet_bytes;
			ev.event_class    = in_q.packet_class;
			ev.event_priority = in_q.priority_level;
			ev.last           = 1'b1;
		end else if (cmd.flush_done) begin
			ev.event_kind = EV_FLUSH;
			ev.last       = 1'b1;
		end
	end

	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:3])
			REG_RATE:   prdata = 64'(rate_q);
			REG_LIMIT:  prdata = 64'(limit_q);
			REG_PERIOD: prdata = 64'(period_q);
			REG_DELAY:  prdata = 64'(delay_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q         <= RATE_RST;
			limit_q        <= LIMIT_RST;
			period_q       <= '0;
			delay_q        <= '0;
			cnt_q          <= '0;
			held_q         <= '0;
			seq_q          <= '0;
			link_free_q    <= '0;
			sorter_free_q  <= '0;
			next_epoch_q   <= '0;
			mul_vld_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[4:3])
					REG_RATE:   rate_q   <= pwdata[39:0];
					REG_LIMIT:  limit_q  <= pwdata[23:0];
					REG_PERIOD: period_q <= pwdata[23:0];
					REG_DELAY:  delay_q  <= pwdata[23:0];
					default:    ;
				endcase
			end
			mul_vld_s1     <= cmd.send;
			result_valid_q <= cmd.send || cmd.evict || cmd.admit || cmd.drop
				|| cmd.flush_done;
			if (cmd.epoch) begin
				sorter_free_q <= sat41(limit, 41'(delay_q));
				next_epoch_q  <= sat41(limit, 41'(gap));
			end
			if (cmd.send || cmd.evict) begin
				held_q <= held_sub;
			end else if (cmd.admit) begin
				held_q <= held_q + 24'(in_q.packet_bytes);
			end
			if (cmd.link_upd) begin
				link_free_q <= sat41(start, quo);
			end
			if (cmd.cnt_set) begin
				cnt_q <= cmd.cnt_val;
			end else if (cmd.admit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.admit) begin
				seq_q <= seq_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
		if (cmd.ent_load) begin
			ent_q <= rdata;
		end
		if (cmd.send) begin
			mul_s1 <= 39'(ent_q.bytes) * 39'(TX_SCALE);
		end
		result_q <= ev;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

@@ design/ppb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppb_ctrl
// Controller: sequences drain, compaction, admission and push-out.
// ----------------------------------------------------------------------------
module ppb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ppb_pkg::status_t st,
	output ppb_pkg::cmd_t    cmd
);
	import ppb_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DECIDE = 5'd1;
	localparam logic [4:0] S_SCAN   = 5'd2;
	localparam logic [4:0] S_SCHK   = 5'd3;
	localparam logic [4:0] S_WAIT   = 5'd4;
	localparam logic [4:0] S_FRD    = 5'd5;
	localparam logic [4:0] S_FLD    = 5'd6;
	localparam logic [4:0] S_FEV    = 5'd7;
	localparam logic [4:0] S_CINIT  = 5'd8;
	localparam logic [4:0] S_CMP    = 5'd9;
	localparam logic [4:0] S_POST   = 5'd10;
	localparam logic [4:0] S_VRD    = 5'd11;
	localparam logic [4:0] S_VEV    = 5'd12;
	localparam logic [4:0] S_VCHK   = 5'd13;
	localparam logic [4:0] S_SRD    = 5'd14;
	localparam logic [4:0] S_SWR    = 5'd15;
	localparam logic [4:0] S_ADM    = 5'd16;

	logic [4:0]             state_q, state_d;
	logic [CNT_W-1:0]       idx_q, idx_d, kept_q, kept_d, rem_q, rem_d;
	logic [IDX_W-1:0]       best_q, best_d, ridx_s1, ridx_d;
	logic                   best_vld_q, best_vld_d, sort_q, sort_d, rv_s1, rv_d;
	logic [QUEUE_SLOTS-1:0] gone_q, gone_d;
	logic [CNT_W-1:0]       idx_nx;

	assign idx_nx = idx_q + CNT_W'(1);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		kept_d     = kept_q;
		rem_d      = rem_q;
		best_d     = best_q;
		best_vld_d = best_vld_q;
		sort_d     = sort_q;
		gone_d     = gone_q;
		rv_d       = 1'b0;
		ridx_d     = ridx_s1;
		cmd        = '0;
		cmd.rd_addr = idx_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				idx_d      = '0;
				gone_d     = '0;
				best_vld_d = 1'b0;
				sort_d     = st.sort_epoch;
				if (st.cnt == '0) begin
					state_d = S_POST;
				end else if (st.sort_epoch) begin
					cmd.epoch = 1'b1;
					state_d   = S_SCAN;
				end else begin
					state_d = S_FRD;
				end
			end
			S_SCAN: begin
				// read one slot a cycle, compare the one read last cycle
				if (idx_q < st.cnt) begin
					rv_d   = 1'b1;
					ridx_d = idx_q[IDX_W-1:0];
					idx_d  = idx_nx;
				end
				if (rv_s1 && !gone_q[ridx_s1] && (!best_vld_q || st.key_lt)) begin
					cmd.ent_load = 1'b1;
					best_d       = ridx_s1;
					best_vld_d   = 1'b1;
				end
				if (idx_q >= st.cnt && !rv_s1) begin
					state_d = best_vld_q ? S_SCHK : S_CINIT;
				end
			end
			S_SCHK: begin
				if (st.start_ok) begin
					cmd.send       = 1'b1;
					gone_d[best_q] = 1'b1;
					state_d        = S_WAIT;
				end else begin
					state_d = S_CINIT;
				end
			end
			S_WAIT: begin
				if (st.div_done) begin
					cmd.link_upd = 1'b1;
					if (sort_q) begin
						idx_d      = '0;
						best_vld_d = 1'b0;
						state_d    = S_SCAN;
					end else begin
						idx_d   = idx_nx;
						state_d = S_FRD;
					end
				end
			end
			S_FRD: begin
				state_d = (idx_q >= st.cnt) ? S_CINIT : S_FLD;
			end
			S_FLD: begin
				cmd.ent_load = 1'b1;
				state_d      = S_FEV;
			end
			S_FEV: begin
				if (st.start_ok) begin
					cmd.send                   = 1'b1;
					gone_d[idx_q[IDX_W-1:0]]   = 1'b1;
					state_d                    = S_WAIT;
				end else begin
					idx_d   = idx_nx;
					state_d = S_FRD;
				end
			end
			S_CINIT: begin
				idx_d   = '0;
				kept_d  = '0;
				state_d = S_CMP;
			end
			S_CMP: begin
				// surviving slots move down to the next free index
				if (idx_q < st.cnt) begin
					rv_d   = 1'b1;
					ridx_d = idx_q[IDX_W-1:0];
					idx_d  = idx_nx;
				end
				if (rv_s1 && !gone_q[ridx_s1]) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = kept_q[IDX_W-1:0];
					kept_d      = kept_q + CNT_W'(1);
				end
				if (idx_q >= st.cnt && !rv_s1) begin
					cmd.cnt_set = 1'b1;
					cmd.cnt_val = kept_q;
					gone_d      = '0;
					state_d     = S_POST;
				end
			end
			S_POST: begin
				if (st.flush) begin
					cmd.flush_done = 1'b1;
					state_d        = S_IDLE;
				end else if (!st.full) begin
					cmd.admit   = 1'b1;
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = st.cnt[IDX_W-1:0];
					state_d     = S_IDLE;
				end else if (st.ctl_push) begin
					idx_d   = st.cnt - CNT_W'(1);
					rem_d   = st.cnt;
					state_d = S_VRD;
				end else begin
					cmd.drop = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_VRD: begin
				if (rem_q == '0) begin
					cmd.drop = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_VEV;
				end
			end
			S_VEV: begin
				// newest bulk slot first
				if (st.rd_bulk) begin
					cmd.ent_load = 1'b1;
					state_d      = S_VCHK;
				end else begin
					idx_d   = idx_q - CNT_W'(1);
					rem_d   = rem_q - CNT_W'(1);
					state_d = S_VRD;
				end
			end
			S_VCHK: begin
				if (st.push_ok) begin
					cmd.evict = 1'b1;
					state_d   = S_SRD;
				end else begin
					cmd.drop = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SRD: begin
				cmd.rd_addr = idx_nx[IDX_W-1:0];
				if (idx_nx < st.cnt) begin
					state_d = S_SWR;
				end else begin
					cmd.cnt_set = 1'b1;
					cmd.cnt_val = st.cnt - CNT_W'(1);
					state_d     = S_ADM;
				end
			end
			S_SWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = idx_q[IDX_W-1:0];
				idx_d       = idx_nx;
				state_d     = S_SRD;
			end
			S_ADM: begin
				cmd.admit   = 1'b1;
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = st.cnt[IDX_W-1:0];
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			kept_q     <= '0;
			rem_q      <= '0;
			best_q     <= '0;
			best_vld_q <= 1'b0;
			sort_q     <= 1'b0;
			gone_q     <= '0;
			rv_s1      <= 1'b0;
			ridx_s1    <= '0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			kept_q     <= kept_d;
			rem_q      <= rem_d;
			best_q     <= best_d;
			best_vld_q <= best_vld_d;
			sort_q     <= sort_d;
			gone_q     <= gone_d;
			rv_s1      <= rv_d;
			ridx_s1    <= ridx_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_admit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.admit |-> st.cnt < CNT_W'(QUEUE_SLOTS))
		else $error("admit with no free slot");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && state_q == S_CMP |-> kept_q <= CNT_W'(ridx_s1))
		else $error("compaction write above its read");

	a_gone_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(gone_q) <= int'(st.cnt))
		else $error("more sent slots than held");

	a_evict_fit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> st.push_ok)
		else $error("push-out overflows byte total");

	a_wait_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT && st.div_done |=> state_q == S_SCAN || state_q == S_FRD)
		else $error("bad exit after transmit time");

endmodule

@@ design/priority_packet_buffer_with_pushout_core.sv @@
// ----------------------------------------------------------------------------
// priority_packet_buffer_with_pushout_core
// Byte-limited pending packet buffer with strict-priority drain and push-out.
// ----------------------------------------------------------------------------
// An item (arrival or flush) is taken when start is high and busy is low.
// Each item first drains every pending packet that can start on the link by
// its time (by tag then age at sort epochs, else in arrival order), then the
// arrival is admitted, dropped, or admitted after evicting the newest bulk
// packet. Each event leaves on result for one cycle with result_valid high;
// the last event of an item carries last. The receiver cannot stall.
// An item with nothing pending gives its one event, and busy drops in the same
// cycle. A drain in arrival order reads the pending slots in turn; at a sort
// epoch each search is a pass over the pending slots, repeated after every
// transmission. A drain over a nonempty buffer adds a compaction pass over the
// slots. Each transmission waits on the one-bit-per-cycle divider for its
// transmit time. Push-out searches slots from the newest and shifts later slots
// down. One item at a time. Registers are to be written over the APB port
// (8-byte stride) only while idle; the block itself does not enforce this.
// Reset empties the buffer and restores the default registers at once.
// ----------------------------------------------------------------------------
module priority_packet_buffer_with_pushout_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppb_pkg::PADDR_W-1:0] paddr,
	input  logic [ppb_pkg::PDATA_W-1:0] pwdata,
	output logic [ppb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  ppb_pkg::item_t              item,
	output ppb_pkg::result_t            result,
	output logic                        result_valid
);
	import ppb_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign pready = 1'b1;

	ppb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	ppb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
